// ===== hw/rtl/bpra_pkg.sv =====
package bpra_pkg;

  localparam int unsigned DefHeapPages = 4096;
  localparam int unsigned DefPageBytes = 4096;
  localparam int unsigned HdrBytes     = 16;
  localparam int unsigned WordBits     = 64;
  localparam int unsigned UsedW        = 25;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_ACHK  = 14'b00000000000100,
    S_SRCH0 = 14'b00000000001000,
    S_SRCH  = 14'b00000000010000,
    S_MRD   = 14'b00000000100000,
    S_MWR   = 14'b00000001000000,
    S_ADR1  = 14'b00000010000000,
    S_ADR2  = 14'b00000100000000,
    S_ADR3  = 14'b00001000000000,
    S_FCALC = 14'b00010000000000,
    S_FRD   = 14'b00100000000000,
    S_FCHK  = 14'b01000000000000,
    S_RESP  = 14'b10000000000000
  } state_e;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

endpackage

// ===== hw/rtl/bpra_ram.sv =====
module bpra_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/bitmap_page_run_allocator.sv =====
// First-fit page allocator over a heap of HEAP_PAGES pages of PAGE_BYTES bytes.
// Input channel (in_valid_i/in_ready_o) carries one request: kind_i 0 allocates
// size_i bytes plus a 16-byte header at alignment 2^align_log2_i, kind_i 1 frees
// the run recorded at the page of address_i. Output channel (out_valid_o /
// out_ready_i) returns one result per request: ok_o, user_address_o, held_bytes_o.
// The user must write heap_base through cfg_we_i/cfg_wdata_i only while the block
// is idle; the block itself does not enforce this. The used map lives in a RAM of
// 64-bit words; the search reads one word per cycle over up to every map word.
// An allocate checks the size, searches, then reads and writes each word that the
// run covers and forms the user address; a free looks up the run length and
// clears each word of the run the same way. A request turned away before any
// search or marking goes straight to its result.
// After reset the block clears both RAMs, one entry per cycle, with in_ready_o
// low until the clearing is done; cfg writes are taken throughout.
// The result sits in an output register: a new request is accepted while it
// waits, and that request holds at its final step until the register frees.
module bitmap_page_run_allocator
  import bpra_pkg::*;
#(
  parameter int unsigned HEAP_PAGES = DefHeapPages,
  parameter int unsigned PAGE_BYTES = DefPageBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] size_i,
  input  logic [3:0]  align_log2_i,
  input  logic [63:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [63:0] user_address_o,
  output logic [UsedW-1:0] held_bytes_o
);

  localparam int unsigned PbLog    = $clog2(PAGE_BYTES);
  localparam int unsigned PgW      = $clog2(HEAP_PAGES);
  localparam int unsigned LenW     = $clog2(HEAP_PAGES + 1);
  localparam int unsigned RunW     = $clog2(HEAP_PAGES + WordBits + 1);
  localparam int unsigned MapWords = (HEAP_PAGES + WordBits - 1) / WordBits;
  localparam int unsigned MwW      = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned TailBits = HEAP_PAGES % WordBits;

  state_e state_q, state_d;

  logic [63:0]     base_q;
  logic            kind_q;
  logic [31:0]     size_q;
  logic [3:0]      alog_q;
  logic [63:0]     addr_q, addr_d;
  logic [LenW-1:0] n_q, n_d;
  logic [PgW-1:0]  start_q, start_d;
  logic [RunW-1:0] run_q, run_d;
  logic [MwW-1:0]  widx_q, widx_d;
  logic            ok_q, ok_d;
  logic [63:0]     cnt_q, cnt_d;
  logic [PgW-1:0]  clr_q;

  logic            out_valid_q;
  logic            out_ok_q;
  logic [63:0]     out_user_q;
  logic [UsedW-1:0] out_held_q;

  // map RAM
  logic            map_we;
  logic [MwW-1:0]  map_waddr, map_raddr;
  logic [63:0]     map_wdata, map_rdata;
  // run length RAM
  logic            len_we;
  logic [PgW-1:0]  len_waddr, len_raddr;
  logic [LenW-1:0] len_wdata, len_rdata;

  bpra_ram #(.Width(WordBits), .Depth(MapWords)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bpra_ram #(.Width(LenW), .Depth(HEAP_PAGES)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // search over one map word
  logic [63:0]      tail_used;
  logic [63:0]      used_bits;
  logic [6:0]       last_pos [64];
  logic [6:0]       last_nxt [64];
  logic [RunW-1:0]  run_at   [64];
  logic [63:0]      hit;
  logic             any_hit;
  logic [5:0]       hit_idx;
  logic [RunW-1:0]  run_out;
  logic [RunW+6:0]  fit_end;
  logic [PgW-1:0]   fit_start;

  always_comb begin
    tail_used = '0;
    if (TailBits != 0 && widx_q == MwW'(MapWords - 1)) begin
      tail_used = ~((64'd1 << TailBits) - 64'd1);
    end
    used_bits = map_rdata | tail_used;
    for (int i = 0; i < 64; i++) begin
      last_pos[i] = used_bits[i] ? 7'(i + 1) : 7'd0;
    end
    // prefix pass: position (+1) of the nearest used bit at or below each bit
    for (int l = 0; l < 6; l++) begin
      for (int i = 0; i < 64; i++) begin
        if (i >= (1 << l) && last_pos[i] == 7'd0) begin
          last_nxt[i] = last_pos[i - (1 << l)];
        end else begin
          last_nxt[i] = last_pos[i];
        end
      end
      last_pos = last_nxt;
    end
    for (int i = 0; i < 64; i++) begin
      if (last_pos[i] == 7'd0) begin
        run_at[i] = run_q + RunW'(i + 1);
      end else begin
        run_at[i] = RunW'(i + 1) - RunW'(last_pos[i]);
      end
      hit[i] = (run_at[i] >= RunW'(n_q));
    end
    any_hit = |hit;
    hit_idx = '0;
    for (int i = 63; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = 6'(i);
      end
    end
    if (last_pos[63] == 7'd0) begin
      run_out = run_q + RunW'(64);
    end else begin
      run_out = RunW'(64) - RunW'(last_pos[63]);
    end
    fit_end   = {widx_q, 6'(0)} + (RunW+7)'(hit_idx) + (RunW+7)'(1) - (RunW+7)'(n_q);
    fit_start = fit_end[PgW-1:0];
  end

  // run marking
  logic [PgW-1:0] last_pg;
  logic [MwW-1:0] first_w, last_w;
  logic [5:0]     lo_bit, hi_bit;
  logic [63:0]    run_mask;

  always_comb begin
    last_pg  = PgW'({1'b0, start_q} + (PgW+1)'(n_q) - (PgW+1)'(1));
    first_w  = MwW'(start_q >> 6);
    last_w   = MwW'(last_pg >> 6);
    lo_bit   = (widx_q == first_w) ? 6'(start_q) : 6'd0;
    hi_bit   = (widx_q == last_w) ? 6'(last_pg) : 6'd63;
    run_mask = ({64{1'b1}} << lo_bit) & ({64{1'b1}} >> (6'd63 - hi_bit));
  end

  // free address decode
  logic [63-PbLog:0]  pg_num;
  logic               pg_in;
  logic [33:0]        pages_req;
  logic [63:0]        run_bytes;
  logic [63:0]        align_m1;
  logic [PgW:0]       free_end;

  always_comb begin
    pg_num    = addr_q[63:PbLog];
    pg_in     = (pg_num < (64-PbLog)'(HEAP_PAGES));
    pages_req = (34'(size_q) + 34'(HdrBytes) + 34'(PAGE_BYTES - 1)) >> PbLog;
    run_bytes = 64'(n_q) << PbLog;
    align_m1  = (64'd1 << alog_q) - 64'd1;
    free_end  = {1'b0, start_q} + (PgW+1)'(len_rdata);
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    n_d      = n_q;
    start_d  = start_q;
    run_d    = run_q;
    widx_d   = widx_q;
    ok_d     = ok_q;
    cnt_d    = cnt_q;
    map_we    = 1'b0;
    map_waddr = widx_q;
    map_wdata = map_rdata;
    map_raddr = widx_q;
    len_we    = 1'b0;
    len_waddr = start_q;
    len_wdata = n_q;
    len_raddr = PgW'(pg_num);

    unique case (state_q)
      S_CLEAR: begin
        map_we    = (clr_q < PgW'(MapWords)) || (MapWords > HEAP_PAGES - 1);
        map_waddr = MwW'(clr_q);
        map_wdata = '0;
        len_we    = 1'b1;
        len_waddr = clr_q;
        len_wdata = '0;
        if (clr_q == PgW'(HEAP_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ok_d = 1'b0;
        if (in_valid_i) begin
          addr_d  = address_i;
          state_d = (kind_i == KindAlloc) ? S_ACHK : S_FCALC;
        end
      end
      S_ACHK: begin
        addr_d = '0;
        if (size_q == 32'd0 || pages_req > 34'(HEAP_PAGES)) begin
          state_d = S_RESP;
        end else begin
          n_d     = LenW'(pages_req);
          state_d = S_SRCH0;
        end
      end
      S_SRCH0: begin
        widx_d    = '0;
        map_raddr = '0;
        run_d     = '0;
        state_d   = S_SRCH;
      end
      S_SRCH: begin
        map_raddr = widx_q + MwW'(1);
        if (any_hit) begin
          start_d = fit_start;
          widx_d  = MwW'(fit_start >> 6);
          ok_d    = 1'b1;
          state_d = S_MRD;
        end else if (widx_q == MwW'(MapWords - 1)) begin
          state_d = S_RESP;
        end else begin
          run_d  = run_out;
          widx_d = widx_q + MwW'(1);
        end
      end
      S_MRD: begin
        map_raddr = widx_q;
        state_d   = S_MWR;
      end
      S_MWR: begin
        map_we    = 1'b1;
        map_wdata = (kind_q == KindAlloc) ? (map_rdata | run_mask) : (map_rdata & ~run_mask);
        if (widx_q == last_w) begin
          if (kind_q == KindAlloc) begin
            len_we  = 1'b1;
            cnt_d   = cnt_q + run_bytes;
            addr_d  = base_q + (64'(start_q) << PbLog);
            state_d = S_ADR2;
          end else begin
            if (cnt_q >= run_bytes) begin
              cnt_d = cnt_q - run_bytes;
            end
            state_d = S_RESP;
          end
        end else begin
          widx_d  = widx_q + MwW'(1);
          state_d = S_MRD;
        end
      end
      S_ADR1: begin
        state_d = S_ADR2;
      end
      S_ADR2: begin
        addr_d  = addr_q + 64'(HdrBytes);
        state_d = S_ADR3;
      end
      S_ADR3: begin
        if (alog_q > 4'd4) begin
          addr_d = (addr_q + align_m1) & ~align_m1;
        end
        state_d = S_RESP;
      end
      S_FCALC: begin
        if (addr_q == 64'd0) begin
          state_d = S_RESP;
        end else begin
          addr_d  = (addr_q & ~64'(PAGE_BYTES - 1)) - base_q;
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        // len_raddr follows the page number of addr_q
        if (pg_in) begin
          start_d = PgW'(pg_num);
          state_d = S_FCHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_FCHK: begin
        if (len_rdata != '0 && len_rdata <= LenW'(HEAP_PAGES) &&
            free_end <= (PgW+1)'(HEAP_PAGES)) begin
          n_d     = len_rdata;
          widx_d  = MwW'(start_q >> 6);
          ok_d    = 1'b1;
          state_d = S_MRD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ok_q    <= ok_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + PgW'(1);
      end
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (state_q == S_RESP && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    n_q     <= n_d;
    start_q <= start_d;
    run_q   <= run_d;
    widx_q  <= widx_d;
    if (state_q == S_IDLE && in_valid_i) begin
      kind_q <= kind_i;
      size_q <= size_i;
      alog_q <= align_log2_i;
    end
    if (state_q == S_RESP && (!out_valid_q || out_ready_i)) begin
      out_ok_q   <= ok_q;
      out_user_q <= (ok_q && kind_q == KindAlloc) ? addr_q : 64'd0;
      out_held_q <= cnt_q[UsedW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign user_address_o = out_user_q;
  assign held_bytes_o   = out_held_q;

endmodule

// ===== dv/tb.sv =====
module tb;
  import bpra_pkg::*;

  localparam int unsigned Pages     = DefHeapPages;
  localparam int unsigned PageSz    = DefPageBytes;
  localparam int unsigned CycleCap  = 3000000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic        kind;
    logic [31:0] size;
    logic [3:0]  align_log2;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [63:0]      user_address;
    logic [UsedW-1:0] held_bytes;
  } res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [31:0] size_i;
  logic [3:0]  align_log2_i;
  logic [63:0] address_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        ok_o;
  logic [63:0] user_address_o;
  logic [UsedW-1:0] held_bytes_o;

  bitmap_page_run_allocator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .size_i         (size_i),
    .align_log2_i   (align_log2_i),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ok_o           (ok_o),
    .user_address_o (user_address_o),
    .held_bytes_o   (held_bytes_o)
  );

  // allocator model state
  logic [63:0] heap_base_q;
  bit          page_busy [Pages];
  int unsigned page_run_len [Pages];
  logic [63:0] byte_count;

  req_t        pending_reqs[$];
  res_t        expected_results[$];
  int unsigned live_starts[$];
  logic [63:0] odd_addrs[$];

  int unsigned errors, cycles, results_seen, issued;
  int unsigned allocs_granted, frees_done, rejects;
  bit          quiet, held;
  int unsigned send_gap, recv_gap, hold_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // work out the result of one accepted request and update the model
  task automatic allocate_or_free(input req_t r);
    res_t        res;
    logic [63:0] total, npages, base, align, user, start64, bytes;
    int unsigned run, start;
    bit          found;
    res = '0;
    if (r.kind == KindAlloc) begin
      if (r.size != 0) begin
        total  = {32'd0, r.size} + HdrBytes;
        npages = (total + PageSz - 1) / PageSz;
        found  = 1'b0;
        run    = 0;
        start  = 0;
        if (npages <= Pages) begin
          for (int unsigned i = 0; i < Pages && !found; i++) begin
            if (page_busy[i]) run = 0;
            else begin
              run++;
              if (run == npages) begin
                found = 1'b1;
                start = i + 1 - run;
              end
            end
          end
        end
        if (found) begin
          for (int unsigned j = 0; j < npages; j++) page_busy[start + j] = 1'b1;
          page_run_len[start] = 32'(npages);
          base  = heap_base_q + 64'(start) * PageSz;
          user  = base + HdrBytes;
          align = 64'd1 << r.align_log2;
          if (align > HdrBytes) user = (user + (align - 1)) & ~(align - 1);
          byte_count = byte_count + npages * PageSz;
          res.ok = 1'b1;
          res.user_address = user;
          live_starts.push_back(start);
          if (user[63:12] != base[63:12]) odd_addrs.push_back(user);
        end
      end
    end else if (r.address != 0) begin
      base    = r.address - (r.address % PageSz);
      start64 = (base - heap_base_q) / PageSz;
      if (start64 < Pages) begin
        npages = 64'(page_run_len[start64]);
        if (npages != 0 && npages <= Pages && start64 + npages <= Pages) begin
          for (int unsigned j = 0; j < npages; j++) page_busy[start64 + j] = 1'b0;
          bytes = npages * PageSz;
          if (byte_count >= bytes) byte_count = byte_count - bytes;
          res.ok = 1'b1;
        end
      end
    end
    res.held_bytes = byte_count[UsedW-1:0];
    if (res.ok && r.kind == KindAlloc) allocs_granted++;
    else if (res.ok) frees_done++;
    else rejects++;
    expected_results.push_back(res);
  endtask

  // driver
  always @(posedge clk_i) begin
    req_t r;
    bit   fire, v;
    fire = in_valid_i && in_ready_o;
    v = in_valid_i;
    if (fire) begin
      r = '{kind_i, size_i, align_log2_i, address_i};
      allocate_or_free(r);
    end
    if (!in_valid_i || fire) begin
      v = 1'b0;
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        issued++;
        kind_i       <= r.kind;
        size_i       <= r.size;
        align_log2_i <= r.align_log2;
        address_i    <= r.address;
        v = 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 13);
      end
    end
    in_valid_i <= v;
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    res_t e;
    bit   rdy;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: ok=%0d user=%h held=%h",
               ok_o, user_address_o, held_bytes_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (ok_o !== e.ok) begin
          $error("ok: expected %0d got %0d", e.ok, ok_o);
          errors++;
        end
        if (user_address_o !== e.user_address) begin
          $error("user_address: expected %h got %h", e.user_address, user_address_o);
          errors++;
        end
        if (held_bytes_o !== e.held_bytes) begin
          $error("held_bytes: expected %h got %h", e.held_bytes, held_bytes_o);
          errors++;
        end
      end
    end
    rdy = 1'b1;
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rdy = 1'b0;
    end else if (!held && results_seen == 300) begin
      held <= 1'b1;
      hold_cnt <= HoldCycles;
      rdy = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      recv_gap <= $urandom_range(0, 12);
      rdy = 1'b0;
    end
    out_ready_i <= rdy;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic req_t mk_alloc(logic [31:0] sz, logic [3:0] al);
    return '{KindAlloc, sz, al, 64'd0};
  endfunction

  function automatic req_t mk_free(logic [63:0] a);
    req_t r;
    r = '{KindFree, 32'(0), 4'(0), a};
    r.size = {$urandom()};
    r.align_log2 = 4'($urandom_range(0, 15));
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || issued != results_seen ||
           expected_results.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_heap_base(input logic [63:0] hb);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hb;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    heap_base_q = hb;
    @(posedge clk_i);
  endtask

  function automatic req_t random_request();
    req_t        r;
    int unsigned k, pick;
    logic [31:0] sz;
    k = $urandom_range(0, 99);
    if (k < 50) begin
      case ($urandom_range(0, 9))
        0:       sz = {$urandom()};
        1:       sz = $urandom_range(1, 16777200);
        2:       sz = 0;
        3, 4:    sz = $urandom_range(4000, 200000);
        default: sz = $urandom_range(1, 12000);
      endcase
      r = mk_alloc(sz, 4'($urandom_range(0, 11)));
    end else if (k < 90 && live_starts.size() > 0) begin
      pick = $urandom_range(0, live_starts.size() - 1);
      r = mk_free(heap_base_q + 64'(live_starts[pick]) * PageSz + $urandom_range(0, PageSz - 1));
      if ($urandom_range(0, 4) != 0) live_starts.delete(pick);
    end else if (k < 93 && odd_addrs.size() > 0) begin
      r = mk_free(odd_addrs.pop_front());
    end else if (k < 95) begin
      r = mk_free(64'd0);
    end else if (k < 97) begin
      r = mk_free(heap_base_q + 64'($urandom_range(0, Pages - 1)) * PageSz);
    end else begin
      r = mk_free({$urandom(), $urandom()});
    end
    return r;
  endfunction

  initial begin
    logic [63:0] bases [4];
    int unsigned batch;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    kind_i = 1'b0;
    size_i = '0;
    align_log2_i = '0;
    address_i = '0;
    out_ready_i = 1'b0;
    errors = 0; cycles = 0; results_seen = 0; issued = 0;
    allocs_granted = 0; frees_done = 0; rejects = 0;
    quiet = 1'b0; held = 1'b0;
    send_gap = 0; recv_gap = 0; hold_cnt = 0;
    heap_base_q = '0;
    byte_count = '0;
    foreach (page_busy[i]) begin
      page_busy[i] = 1'b0;
      page_run_len[i] = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_heap_base(64'd0);

    // directed: empty heap, known placement from page zero
    pending_reqs.push_back(mk_alloc(32'd0, 4'd4));
    pending_reqs.push_back(mk_alloc(32'hFFFF_FFFF, 4'd4));
    pending_reqs.push_back(mk_alloc(32'd16777200, 4'd4));  // whole heap
    pending_reqs.push_back(mk_alloc(32'd1, 4'd4));         // no room left
    pending_reqs.push_back(mk_free(64'h10));
    pending_reqs.push_back(mk_free(64'h10));               // stale length, count underflow
    pending_reqs.push_back(mk_free(64'd0));
    pending_reqs.push_back(mk_free(64'hFFFF_FFFF_FFFF_F010)); // outside heap
    pending_reqs.push_back(mk_alloc(32'd1, 4'd11));
    pending_reqs.push_back(mk_alloc(32'd4080, 4'd0));
    pending_reqs.push_back(mk_alloc(32'd4081, 4'd4));
    pending_reqs.push_back(mk_alloc(32'd16777201, 4'd15));
    pending_reqs.push_back(mk_free(64'h3005));             // page with no run
    pending_reqs.push_back(mk_free(64'h800));
    pending_reqs.push_back(mk_free(64'h2000));
    pending_reqs.push_back(mk_free(64'h1FFF));
    pending_reqs.push_back(mk_free(64'hFFFF_FFFF_FFFF_FFFF));
    drain();
    live_starts.delete();

    bases[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    bases[1] = {$urandom(), $urandom()};
    bases[2] = 64'hFFFF_FFFF_FFFF_0000;
    bases[3] = 64'd0;
    for (int p = 0; p < 4; p++) begin
      set_heap_base(bases[p]);
      for (batch = 0; batch < 12; batch++) begin
        if (p == 3 && batch >= 8) quiet = 1'b1;
        for (int n = 0; n < 16; n++) pending_reqs.push_back(random_request());
        drain();
      end
    end

    repeat (50) @(posedge clk_i);
    $display("covered %0d results: %0d granted allocations, %0d frees, %0d rejected",
             results_seen, allocs_granted, frees_done, rejects);
    $display("four heap base settings, long output stall and idle bursts on both sides");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
